// File: rtl/srgb_fb_pkg.sv
// Shared types, register codes and the sRGB encode table for the frame buffer.
package srgb_fb_pkg;

    // Configuration register indexes and widths
    localparam int CFG_W = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 9'd256;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 9'd256;

    // Payload widths
    localparam int COORD_W = 16;
    localparam int LIN_W = 16;
    localparam int CODE_W = 8;
    localparam int PIXEL_W = 3 * CODE_W;

    // Operation codes
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Encode table: one byte for each clamped linear value 0..4096
    localparam int ENC_ENTRIES = 4097;
    localparam int ENC_IDX_W = 13;
    localparam logic [ENC_IDX_W-1:0] ENC_ONE = 13'd4096;
    localparam int ENC_TABLE_W = ENC_ENTRIES * CODE_W;
    localparam int WIDE_W = 240;
    // last linear value on the straight segment (c <= 0.0031308 in Q3.12)
    localparam int LIN_LAST = (31308 * 4096) / 10000000;

    // Commands from the pipeline to the pixel store
    typedef struct packed {
        logic wr;
        logic rd;
    } fb_mem_cmd_t;

    // base^nb * mult^nm in wide integer arithmetic
    function automatic logic [WIDE_W-1:0] enc_scaled(int base, int nb, int mult, int nm);
        logic [WIDE_W-1:0] acc;
        acc = WIDE_W'(1);
        for (int i = 0; i < nb; i++)
            acc = acc * WIDE_W'(base);
        for (int i = 0; i < nm; i++)
            acc = acc * WIDE_W'(mult);
        return acc;
    endfunction

    // Exact rounding of 255 * encoded value. Power segment: code k is reached when
    // c^5 * 10761^12 >= (40k+541)^12 * 4096^5; the code only grows with c.
    function automatic logic [ENC_TABLE_W-1:0] enc_build_table();
        logic [ENC_TABLE_W-1:0] tbl;
        logic [WIDE_W-1:0] lhs;
        logic [WIDE_W-1:0] rhs;
        int code;
        int entry;
        tbl = '0;
        code = 0;
        rhs = enc_scaled(581, 12, 4096, 5);
        for (int c = 0; c < ENC_ENTRIES; c++) begin
            if (c <= LIN_LAST) begin
                entry = (c * 65892 + 40960) / 81920;
            end
            else begin
                lhs = enc_scaled(c, 5, 10761, 12);
                while (code < 255 && lhs >= rhs) begin
                    code = code + 1;
                    rhs = enc_scaled(40 * (code + 1) + 541, 12, 4096, 5);
                end
                entry = code;
            end
            tbl[c * CODE_W +: CODE_W] = CODE_W'(entry);
        end
        return tbl;
    endfunction

    localparam logic [ENC_TABLE_W-1:0] ENC_TABLE = enc_build_table();

endpackage

// File: rtl/srgb_fb_encoder.sv
// Clamp of three linear channels and registered lookup in the sRGB encode ROM.
module srgb_fb_encoder (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [srgb_fb_pkg::LIN_W-1:0] red_lin,
    input  logic signed [srgb_fb_pkg::LIN_W-1:0] green_lin,
    input  logic signed [srgb_fb_pkg::LIN_W-1:0] blue_lin,
    output logic [srgb_fb_pkg::PIXEL_W-1:0]     pixel
);
    import srgb_fb_pkg::*;

    logic [ENC_IDX_W-1:0] red_idx;
    logic [ENC_IDX_W-1:0] green_idx;
    logic [ENC_IDX_W-1:0] blue_idx;
    logic [CODE_W-1:0]    red_reg;
    logic [CODE_W-1:0]    green_reg;
    logic [CODE_W-1:0]    blue_reg;

    // clamp to 0..1.0
    function automatic logic [ENC_IDX_W-1:0] clamp_lin(logic signed [LIN_W-1:0] v);
        logic [ENC_IDX_W-1:0] r;
        if (v[LIN_W-1])
            r = '0;
        else if (v > LIN_W'(ENC_ONE))
            r = ENC_ONE;
        else
            r = v[ENC_IDX_W-1:0];
        return r;
    endfunction

    assign red_idx   = clamp_lin(red_lin);
    assign green_idx = clamp_lin(green_lin);
    assign blue_idx  = clamp_lin(blue_lin);

    // ROM reads, one port per channel
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= ENC_TABLE[{red_idx, 3'b000} +: CODE_W];
            green_reg <= ENC_TABLE[{green_idx, 3'b000} +: CODE_W];
            blue_reg  <= ENC_TABLE[{blue_idx, 3'b000} +: CODE_W];
        end
    end

    assign pixel = {red_reg, green_reg, blue_reg};

endmodule

// File: rtl/srgb_fb_store.sv
// Pixel store: single-port synchronous RAM with a clearing sweep after reset.
module srgb_fb_store #(
    parameter int DEPTH = 65536,
    parameter int AW = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  srgb_fb_pkg::fb_mem_cmd_t           cmd,
    input  logic [AW-1:0]                      addr,
    input  logic [srgb_fb_pkg::PIXEL_W-1:0]    wdata,
    output logic [srgb_fb_pkg::PIXEL_W-1:0]    rdata,
    output logic                               clearing
);
    import srgb_fb_pkg::*;

    logic [PIXEL_W-1:0] mem [0:DEPTH-1];
    logic [PIXEL_W-1:0] rdata_reg;
    logic               clearing_reg;
    logic               clearing_next;
    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      clr_addr_next;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [PIXEL_W-1:0] mem_wdata;

    // clearing sweep, one entry a cycle
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
                clearing_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // write port shared by the sweep and the pipeline
    assign mem_we    = clearing_reg || cmd.wr;
    assign mem_waddr = clearing_reg ? clr_addr_reg : addr;
    assign mem_wdata = clearing_reg ? '0 : wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.rd)
            rdata_reg <= mem[addr];
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

// File: rtl/srgb_encoding_frame_buffer.sv
// Top level: sRGB-encoding frame buffer with address pipeline and output register.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------------
//   input    | in_valid / in_stall       | kind, pos_x, pos_y, red/green/blue_linear
//   output   | out_valid / out_stall     | red_code, green_code, blue_code, in_range
//   config   | cfg_write                 | cfg_index, cfg_data
//
// out_valid rises once the input transaction has passed stage 1, stage 2 and the output
// register; one transaction per cycle while the output is taken and the sweep is done,
// set by the single store port used once per item. After reset all MAX_WIDTH*MAX_HEIGHT
// store entries (65536 by default) are swept to zero with in_stall high; config writes
// are taken during the sweep. A stalled output freezes the whole pipeline and raises in_stall.
module srgb_encoding_frame_buffer #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_write,
    input  logic [srgb_fb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [srgb_fb_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic                                       kind,
    input  logic signed [srgb_fb_pkg::COORD_W-1:0]     pos_x,
    input  logic signed [srgb_fb_pkg::COORD_W-1:0]     pos_y,
    input  logic signed [srgb_fb_pkg::LIN_W-1:0]       red_linear,
    input  logic signed [srgb_fb_pkg::LIN_W-1:0]       green_linear,
    input  logic signed [srgb_fb_pkg::LIN_W-1:0]       blue_linear,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic [srgb_fb_pkg::CODE_W-1:0]             red_code,
    output logic [srgb_fb_pkg::CODE_W-1:0]             green_code,
    output logic [srgb_fb_pkg::CODE_W-1:0]             blue_code,
    output logic                                       in_range
);
    import srgb_fb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int XCW   = (XW > CFG_W) ? XW : CFG_W;
    localparam int YCW   = (YW > CFG_W) ? YW : CFG_W;
    localparam int XIW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YIW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW    = YIW + XW + 1;

    // configuration
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective size, saturated at the store dimensions
    logic [XW-1:0] wd;
    logic [YW-1:0] ht;
    assign wd = (XCW'(image_width_reg) > XCW'(MAX_WIDTH)) ? XW'(MAX_WIDTH)
                                                          : XW'(image_width_reg);
    assign ht = (YCW'(image_height_reg) > YCW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
                                                            : YW'(image_height_reg);

    // range check and address
    logic          coord_ok;
    logic [PW-1:0] addr_full;
    assign coord_ok = !pos_x[COORD_W-1] && !pos_y[COORD_W-1]
                   && (pos_x < COORD_W'(wd)) && (pos_y < COORD_W'(ht));
    assign addr_full = PW'(pos_y[YIW-1:0]) * PW'(wd) + PW'(pos_x[XIW-1:0]);

    // handshake
    logic adv;
    logic accept;
    logic clearing;
    logic out_valid_reg;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = clearing || !adv;
    assign accept   = in_valid && !in_stall;

    // stage 1: address, kind, range
    logic          s1_valid_reg;
    logic          s1_kind_reg;
    logic          s1_ok_reg;
    logic [AW-1:0] s1_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= kind;
            s1_ok_reg   <= coord_ok;
            s1_addr_reg <= addr_full[AW-1:0];
        end
    end

    // encode ROM, result lines up with stage 1
    logic [PIXEL_W-1:0] enc_pixel;

    srgb_fb_encoder u_encoder (
        .clk       (clk),
        .en        (accept),
        .red_lin   (red_linear),
        .green_lin (green_linear),
        .blue_lin  (blue_linear),
        .pixel     (enc_pixel)
    );

    // store access from stage 1
    fb_mem_cmd_t        mem_cmd;
    logic [PIXEL_W-1:0] mem_rdata;
    assign mem_cmd.wr = adv && s1_valid_reg && (s1_kind_reg == KIND_WRITE) && s1_ok_reg;
    assign mem_cmd.rd = adv && s1_valid_reg && (s1_kind_reg == KIND_READ) && s1_ok_reg;

    srgb_fb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mem_cmd),
        .addr     (s1_addr_reg),
        .wdata    (enc_pixel),
        .rdata    (mem_rdata),
        .clearing (clearing)
    );

    // stage 2: store read data arrives
    logic               s2_valid_reg;
    logic               s2_kind_reg;
    logic               s2_ok_reg;
    logic [PIXEL_W-1:0] s2_enc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_ok_reg   <= s1_ok_reg;
            s2_enc_reg  <= enc_pixel;
        end
    end

    // output register
    logic [PIXEL_W-1:0] res_next;
    logic [PIXEL_W-1:0] res_reg;
    logic               in_range_reg;

    always_comb
    begin
        if (s2_kind_reg == KIND_WRITE)
            res_next = s2_enc_reg;
        else if (s2_ok_reg)
            res_next = mem_rdata;
        else
            res_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            res_reg      <= res_next;
            in_range_reg <= s2_ok_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_code   = res_reg[2*CODE_W +: CODE_W];
    assign green_code = res_reg[CODE_W +: CODE_W];
    assign blue_code  = res_reg[0 +: CODE_W];
    assign in_range   = in_range_reg;

endmodule

// File: sim/srgb_encoding_frame_buffer_test.sv
// Self-checking testbench for the sRGB-encoding frame buffer: random traffic, scoreboard, watchdog.

// Codes expected for one output transaction
typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit       in_range;
} pixel_codes_t;

// Predicts each result from its own copy of the store and the size registers
class frame_checker;
    localparam int MAX_W = 256;
    localparam int MAX_H = 256;

    bit [23:0]    pixel_mem [MAX_W*MAX_H];
    bit [8:0]     width_reg;
    bit [8:0]     height_reg;
    bit [7:0]     gamma_lut [4097];
    pixel_codes_t pending_codes [$];
    int           errors;

    // base^n in 256-bit integer arithmetic
    static function bit [255:0] wide_pow(int base, int n);
        bit [255:0] acc;
        acc = 256'd1;
        for (int i = 0; i < n; i++)
            acc = acc * 256'(base);
        return acc;
    endfunction

    // Build the byte for every clamped linear value 0..4096.
    // Power segment: code k is reached when c^5 * 10761^12 >= (40k+541)^12 * 4096^5.
    function new();
        bit [255:0] bound [256];
        bit [255:0] lhs;
        bit [255:0] scale;
        int lo;
        int hi;
        int mid;
        scale = wide_pow(4096, 5);
        for (int k = 1; k < 256; k++)
            bound[k] = wide_pow(40 * k + 541, 12) * scale;
        for (int c = 0; c <= 4096; c++) begin
            if (c * 10000000.0 <= 31308.0 * 4096.0) begin
                gamma_lut[c] = 8'((c * 65892 + 40960) / 81920);
            end
            else begin
                lhs = wide_pow(c, 5) * wide_pow(10761, 12);
                lo = 0;
                hi = 255;
                while (lo < hi) begin
                    mid = (lo + hi + 1) / 2;
                    if (lhs >= bound[mid])
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                gamma_lut[c] = 8'(lo);
            end
        end
        width_reg = srgb_fb_pkg::IMAGE_WIDTH_RESET;
        height_reg = srgb_fb_pkg::IMAGE_HEIGHT_RESET;
        errors = 0;
        foreach (pixel_mem[i])
            pixel_mem[i] = '0;
    endfunction

    function void set_reg(bit [srgb_fb_pkg::CFG_IDX_W-1:0] idx, bit [8:0] data);
        if (idx == srgb_fb_pkg::REG_IMAGE_WIDTH)
            width_reg = data;
        else if (idx == srgb_fb_pkg::REG_IMAGE_HEIGHT)
            height_reg = data;
    endfunction

    // Clamp to 0..1.0 and look up the sRGB byte
    function bit [7:0] encode_linear(bit signed [15:0] lin);
        int v;
        v = lin;
        if (v < 0)
            v = 0;
        if (v > 4096)
            v = 4096;
        return gamma_lut[v];
    endfunction

    // Accepted input transaction: update the store and queue the expected codes
    function void note_item(bit k, bit signed [15:0] x, bit signed [15:0] y,
                            bit signed [15:0] r, bit signed [15:0] g, bit signed [15:0] b);
        int wd;
        int ht;
        int xi;
        int yi;
        int addr;
        bit ok;
        pixel_codes_t e;
        wd = (width_reg > MAX_W) ? MAX_W : width_reg;
        ht = (height_reg > MAX_H) ? MAX_H : height_reg;
        xi = x;
        yi = y;
        ok = xi >= 0 && yi >= 0 && xi < wd && yi < ht;
        addr = ok ? yi * wd + xi : 0;
        if (k == srgb_fb_pkg::KIND_WRITE) begin
            e.red = encode_linear(r);
            e.green = encode_linear(g);
            e.blue = encode_linear(b);
            if (ok)
                pixel_mem[addr] = {e.red, e.green, e.blue};
        end
        else if (ok) begin
            {e.red, e.green, e.blue} = pixel_mem[addr];
        end
        else begin
            e.red = '0;
            e.green = '0;
            e.blue = '0;
        end
        e.in_range = ok;
        pending_codes.push_back(e);
    endfunction

    // Accepted output transaction: compare with the oldest expectation
    function void check_codes(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic ir);
        pixel_codes_t e;
        if (pending_codes.size() == 0) begin
            $error("unexpected result: red_code=%0d green_code=%0d blue_code=%0d in_range=%0b",
                   r, g, b, ir);
            errors++;
            return;
        end
        e = pending_codes.pop_front();
        if (e.red !== r) begin
            $error("red_code: expected %0d, actual %0d", e.red, r);
            errors++;
        end
        if (e.green !== g) begin
            $error("green_code: expected %0d, actual %0d", e.green, g);
            errors++;
        end
        if (e.blue !== b) begin
            $error("blue_code: expected %0d, actual %0d", e.blue, b);
            errors++;
        end
        if (e.in_range !== ir) begin
            $error("in_range: expected %0b, actual %0b", e.in_range, ir);
            errors++;
        end
    endfunction

    function int pending();
        return pending_codes.size();
    endfunction
endclass

module srgb_encoding_frame_buffer_test;
    import srgb_fb_pkg::*;

    localparam int MAX_W = 256;
    localparam int MAX_H = 256;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 6;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      kind = KIND_WRITE;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic signed [LIN_W-1:0]   red_linear = '0;
    logic signed [LIN_W-1:0]   green_linear = '0;
    logic signed [LIN_W-1:0]   blue_linear = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [CODE_W-1:0]         red_code;
    logic [CODE_W-1:0]         green_code;
    logic [CODE_W-1:0]         blue_code;
    logic                      in_range;

    frame_checker sb;
    bit           no_idle = 1'b0;
    bit           hold_req = 1'b0;
    int           idle_count = 0;

    srgb_encoding_frame_buffer #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .red_linear  (red_linear),
        .green_linear(green_linear),
        .blue_linear (blue_linear),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_code    (red_code),
        .green_code  (green_code),
        .blue_code   (blue_code),
        .in_range    (in_range)
    );

    always #5 clk = ~clk;

    // Monitors on both channels, plus the no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n && in_valid === 1'b1 && in_stall === 1'b0)
            sb.note_item(kind, pos_x, pos_y, red_linear, green_linear, blue_linear);
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_codes(red_code, green_code, blue_code, in_range);
        if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off on request
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (no_idle) begin
                out_stall <= 1'b0;
            end
            else begin
                out_stall <= ($urandom_range(99) < 13);
            end
        end
    end

    // Offer one input transaction and wait until it is taken
    task automatic send_item(logic k, int x, int y, int r, int g, int b);
        if (!no_idle && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        pos_x <= COORD_W'(x);
        pos_y <= COORD_W'(y);
        red_linear <= LIN_W'(r);
        green_linear <= LIN_W'(g);
        blue_linear <= LIN_W'(b);
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // Stop offering and wait until every expected result has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(int w, int h);
        cfg_write <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= CFG_W'(w);
        @(posedge clk);
        sb.set_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= CFG_W'(h);
        @(posedge clk);
        sb.set_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        cfg_write <= 1'b0;
    endtask

    // Coordinates: half in a small corner so reads hit written pixels, plus full range, edges and noise
    function automatic int pick_coord(int limit);
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return $urandom_range(0, (limit < 12) ? limit : 12);
        else if (r < 75)
            return $urandom_range(0, limit);
        else if (r < 85)
            return limit - int'($urandom_range(0, 1));
        else
            return int'($urandom) % 65536;
    endfunction

    function automatic int pick_linear();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return $urandom_range(0, 16);
        else if (r < 65)
            return $urandom_range(0, 4096);
        else if (r < 75)
            return 4094 + int'($urandom_range(0, 4));
        else
            return int'($urandom) % 65536;
    endfunction

    // One size setting followed by random traffic
    task automatic run_phase(int w, int h, int n, bit quiet, bit press);
        int wd;
        int ht;
        wait_idle();
        write_size(w, h);
        wd = (w > MAX_W) ? MAX_W : w;
        ht = (h > MAX_H) ? MAX_H : h;
        no_idle = quiet;
        for (int i = 0; i < n; i++) begin
            if (press && i == n / 3)
                hold_req = 1'b1;
            send_item($urandom_range(0, 1) ? KIND_READ : KIND_WRITE,
                      pick_coord(wd), pick_coord(ht),
                      pick_linear(), pick_linear(), pick_linear());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Size registers are taken during the clearing sweep
        write_size(256, 256);

        // Directed: curve ends, clamping, range edges, ignored writes
        send_item(KIND_WRITE, 0, 0, 0, 4096, 12);
        send_item(KIND_WRITE, 1, 0, 13, -1, 4097);
        send_item(KIND_WRITE, 255, 255, -32768, 32767, 1);
        send_item(KIND_WRITE, 2, 0, 2048, 4095, 100);
        send_item(KIND_READ, 0, 0, 32767, -32768, 4096);
        send_item(KIND_READ, 1, 0, 0, 0, 0);
        send_item(KIND_READ, 255, 255, 0, 0, 0);
        send_item(KIND_READ, 3, 0, 0, 0, 0);
        send_item(KIND_WRITE, 256, 0, 4096, 4096, 4096);
        send_item(KIND_WRITE, 0, 256, 4096, 4096, 4096);
        send_item(KIND_WRITE, -1, 0, 4096, 4096, 4096);
        send_item(KIND_WRITE, 0, -32768, 4096, 4096, 4096);
        send_item(KIND_WRITE, 32767, 32767, 4096, 4096, 4096);
        send_item(KIND_READ, 256, 0, 0, 0, 0);
        send_item(KIND_READ, -32768, -1, 0, 0, 0);
        send_item(KIND_WRITE, 5, 5, 1000, 2000, 3000);
        send_item(KIND_WRITE, 5, -5, 0, 0, 0);
        send_item(KIND_READ, 5, 5, 0, 0, 0);
        send_item(KIND_READ, 255, 0, 0, 0, 0);
        send_item(KIND_WRITE, 0, 255, 12, 13, 14);
        send_item(KIND_READ, 0, 255, 0, 0, 0);

        // Random phases over several sizes, saturation and zero sizes included
        run_phase(256, 256, 400, 1'b0, 1'b1);
        run_phase(511, 300, 200, 1'b0, 1'b0);
        run_phase(0, 5, 60, 1'b0, 1'b0);
        run_phase(7, 0, 60, 1'b0, 1'b0);
        run_phase(1, 1, 80, 1'b0, 1'b0);
        run_phase(5, 3, 250, 1'b1, 1'b0);
        run_phase(256, 1, 150, 1'b0, 1'b0);
        run_phase(13, 256, 300, 1'b0, 1'b0);

        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
